// ===== hw/rtl/kas_pkg.sv =====
// Shared types and constants for the keep-alive supervisor.
package kas_pkg;

  // Session modes.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [1:0] MODE_PENDING = 2'd2;

  // Request types.
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_RESP  = 3'd2;
  localparam logic [2:0] REQ_ERROR = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;
  localparam logic [2:0] REQ_SEND  = 3'd5;

  // Response codes that close the session.
  localparam logic [9:0] CODE_CLOSE_A = 10'd600;
  localparam logic [9:0] CODE_CLOSE_B = 10'd601;
  localparam logic [9:0] CODE_CLOSE_C = 10'd604;

  // Reload period derivation: half less the margin when half reaches twice the margin.
  localparam logic [15:0] RELOAD_MARGIN = 16'd60;
  localparam logic [15:0] RELOAD_LIMIT  = 16'd120;

  // Register indexes and reset values.
  localparam logic REG_MAX_RETRIES     = 1'b0;
  localparam logic REG_MAX_SCHED_ERRS  = 1'b1;
  localparam logic [3:0] MAX_RETRIES_RST    = 4'd1;
  localparam logic [3:0] MAX_SCHED_ERRS_RST = 4'd3;

  // Counter saturation value.
  localparam logic [3:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [3:0] max_retries;
    logic [3:0] max_schedule_errors;
  } kas_cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] interval;
    logic [9:0]  resp_code;
    logic        tid_matches;
    logic        send_failed;
  } kas_item_t;

  typedef struct packed {
    logic       send_request;
    logic       resume_hint;
    logic       logout;
    logic [1:0] mode;
    logic [3:0] retry_count;
    logic [3:0] schedule_fail_count;
  } kas_result_t;

endpackage

// ===== hw/rtl/kas_cfg.sv =====
// Configuration register file behind the APB-style port.
module kas_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output kas_pkg::kas_cfg_t cfg
);

  logic [3:0] max_retries_r;
  logic [3:0] max_sched_errs_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r    <= kas_pkg::MAX_RETRIES_RST;
      max_sched_errs_r <= kas_pkg::MAX_SCHED_ERRS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        kas_pkg::REG_MAX_RETRIES:    max_retries_r    <= pwdata[3:0];
        kas_pkg::REG_MAX_SCHED_ERRS: max_sched_errs_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      kas_pkg::REG_MAX_RETRIES:    prdata = {28'd0, max_retries_r};
      kas_pkg::REG_MAX_SCHED_ERRS: prdata = {28'd0, max_sched_errs_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.max_retries         = max_retries_r;
  assign cfg.max_schedule_errors = max_sched_errs_r;

endmodule

// ===== hw/rtl/kas_core.sv =====
// Session state and the combinational next-state logic for one item.
module kas_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  kas_pkg::kas_item_t   item,
  input  kas_pkg::kas_cfg_t    cfg,
  output kas_pkg::kas_result_t res
);

  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] period_r, period_nxt;
  logic        run_r, run_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [3:0]  sched_r, sched_nxt;
  logic        was_sched_r, was_sched_nxt;
  logic        from_active_r, from_active_nxt;

  logic [4:0]  retry_inc;
  logic [4:0]  sched_inc;
  logic [3:0]  retry_sat;
  logic [3:0]  sched_sat;
  logic [15:0] half;
  logic [15:0] reload_new;
  logic        close_code;

  logic        do_err;
  logic [1:0]  err_mode;
  logic        do_req;
  logic        req_sched;
  logic        close;
  logic        send;
  logic        resume;

  // Incremented counters, kept one bit wider for the limit compares.
  assign retry_inc = {1'b0, retry_r} + 5'd1;
  assign sched_inc = {1'b0, sched_r} + 5'd1;
  assign retry_sat = retry_inc[4] ? kas_pkg::CNT_MAX : retry_inc[3:0];
  assign sched_sat = sched_inc[4] ? kas_pkg::CNT_MAX : sched_inc[3:0];

  // Reload period from the server interval.
  assign half       = {1'b0, item.interval[15:1]};
  assign reload_new = (half >= kas_pkg::RELOAD_LIMIT) ? half - kas_pkg::RELOAD_MARGIN : half;

  assign close_code = (item.resp_code == kas_pkg::CODE_CLOSE_A) ||
                      (item.resp_code == kas_pkg::CODE_CLOSE_B) ||
                      (item.resp_code == kas_pkg::CODE_CLOSE_C);

  // Next state: request decode, then error handling, then keep-alive request,
  // then session close, in that order.
  always_comb begin
    mode_nxt        = mode_r;
    reload_nxt      = reload_r;
    count_nxt       = count_r;
    period_nxt      = period_r;
    run_nxt         = run_r;
    retry_nxt       = retry_r;
    sched_nxt       = sched_r;
    was_sched_nxt   = was_sched_r;
    from_active_nxt = from_active_r;
    do_err          = 1'b0;
    err_mode        = mode_r;
    do_req          = 1'b0;
    req_sched       = 1'b0;
    close           = 1'b0;
    send            = 1'b0;
    resume          = 1'b0;

    case (item.req_type)
      kas_pkg::REQ_START: begin
        mode_nxt   = kas_pkg::MODE_ACTIVE;
        retry_nxt  = 4'd0;
        sched_nxt  = 4'd0;
        reload_nxt = reload_new;
        if (reload_new != 16'd0) begin
          period_nxt = reload_new;
          count_nxt  = reload_new;
          run_nxt    = 1'b1;
        end
      end
      kas_pkg::REQ_STOP: begin
        run_nxt   = 1'b0;
        count_nxt = 16'd0;
        mode_nxt  = kas_pkg::MODE_IDLE;
      end
      kas_pkg::REQ_RESP: begin
        if (mode_r != kas_pkg::MODE_PENDING) begin
          if (reload_r != 16'd0) begin
            period_nxt = reload_r;
            count_nxt  = reload_r;
            run_nxt    = 1'b1;
          end
        end else if (!close_code) begin
          mode_nxt  = kas_pkg::MODE_ACTIVE;
          retry_nxt = 4'd0;
          sched_nxt = 4'd0;
        end else begin
          close = 1'b1;
        end
      end
      kas_pkg::REQ_ERROR: begin
        if (mode_r == kas_pkg::MODE_PENDING && item.tid_matches) begin
          do_err   = 1'b1;
          err_mode = kas_pkg::MODE_ACTIVE;
        end
      end
      kas_pkg::REQ_TICK: begin
        if (run_r) begin
          if (count_r <= 16'd1) begin
            count_nxt = period_r;
            do_req    = 1'b1;
            req_sched = 1'b1;
          end else begin
            count_nxt = count_r - 16'd1;
          end
        end
      end
      kas_pkg::REQ_SEND: begin
        if (mode_r == kas_pkg::MODE_PENDING && item.send_failed) begin
          do_err   = 1'b1;
          err_mode = from_active_r ? kas_pkg::MODE_ACTIVE : kas_pkg::MODE_PENDING;
        end
      end
      default: ;
    endcase

    // Failure handling: the retry count advances first, then either an immediate
    // retry follows or, past the retry limit, a schedule failure if the request was scheduled.
    if (do_err) begin
      mode_nxt  = err_mode;
      retry_nxt = retry_sat;
      if (retry_inc > {1'b0, cfg.max_retries}) begin
        if (was_sched_r) begin
          sched_nxt = sched_sat;
          retry_nxt = 4'd0;
          if (sched_inc > {1'b0, cfg.max_schedule_errors} && err_mode != kas_pkg::MODE_IDLE) begin
            close = 1'b1;
          end
        end
      end else begin
        resume = 1'b1;
        if (err_mode != kas_pkg::MODE_IDLE) begin
          do_req    = 1'b1;
          req_sched = was_sched_r;
        end
      end
    end

    // Keep-alive request.
    if (do_req) begin
      if (mode_nxt == kas_pkg::MODE_ACTIVE) begin
        mode_nxt        = kas_pkg::MODE_PENDING;
        was_sched_nxt   = req_sched;
        from_active_nxt = 1'b1;
        send            = 1'b1;
      end else if (mode_nxt == kas_pkg::MODE_PENDING) begin
        if (req_sched) begin
          sched_nxt = sched_sat;
          retry_nxt = 4'd0;
        end
        if (req_sched && sched_inc > {1'b0, cfg.max_schedule_errors}) begin
          close = 1'b1;
        end else begin
          from_active_nxt = 1'b0;
          send            = 1'b1;
        end
      end
    end

    // Session close stops the timer and logs out.
    if (close) begin
      run_nxt   = 1'b0;
      count_nxt = 16'd0;
      mode_nxt  = kas_pkg::MODE_IDLE;
    end
  end

  // State registers advance once per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= kas_pkg::MODE_IDLE;
      reload_r      <= 16'd0;
      count_r       <= 16'd0;
      period_r      <= 16'd0;
      run_r         <= 1'b0;
      retry_r       <= 4'd0;
      sched_r       <= 4'd0;
      was_sched_r   <= 1'b0;
      from_active_r <= 1'b0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      reload_r      <= reload_nxt;
      count_r       <= count_nxt;
      period_r      <= period_nxt;
      run_r         <= run_nxt;
      retry_r       <= retry_nxt;
      sched_r       <= sched_nxt;
      was_sched_r   <= was_sched_nxt;
      from_active_r <= from_active_nxt;
    end
  end

  assign res.send_request        = send;
  assign res.resume_hint         = resume;
  assign res.logout              = close;
  assign res.mode                = mode_nxt;
  assign res.retry_count         = retry_nxt;
  assign res.schedule_fail_count = sched_nxt;

`ifndef ASSERT_OFF
  // A logout always leaves the session idle.
  a_logout_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.logout |-> res.mode == kas_pkg::MODE_IDLE)
    else $error("logout without idle mode");

  // A keep-alive request always leaves the session pending.
  a_send_pending: assert property (@(posedge clk) disable iff (!rst_n)
    res.send_request |-> res.mode == kas_pkg::MODE_PENDING)
    else $error("send request without pending mode");

  // A running timer never holds a zero count, a stopped one always does.
  a_timer_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == (count_r != 16'd0))
    else $error("timer count inconsistent with running flag");

  // A stop transfer leaves the session idle.
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type == kas_pkg::REQ_STOP |=> mode_r == kas_pkg::MODE_IDLE)
    else $error("stop did not go idle");
`endif

endmodule

// ===== hw/rtl/keepalive_supervisor_top.sv =====
// Top level of the keep-alive supervisor: input stage, core and result stage.
//
// Usage: each input transfer carries one request (start, stop, response,
// transport error, one-second tick or send outcome) and produces exactly one
// result transfer with the keep-alive request, resume hint, logout flag, the
// mode after the request and both failure counters.
// Both channels transfer on a rising edge with valid high and stall low.
// The item sits in the input register until the result stage can take it; then
// the session state and the result register, with out_valid, update together
// at that edge. Throughput is one item per cycle while the receiver does not
// stall; the next-state logic of the session state is the only loop.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, after which in_stall rises until the result is taken.
// The user is to write the two limit registers over the APB-style port only
// while the block is idle, which the block does not enforce; pready is always
// high and reads return the register values.
// Reset (rst_n low, synchronous) empties both stages, makes the session idle
// with the timer stopped and counters cleared, and restores the limits to
// one retry and three schedule failures.
module keepalive_supervisor_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_interval,
  input  logic [9:0]  in_resp_code,
  input  logic        in_tid_matches,
  input  logic        in_send_failed,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_request,
  output logic        out_resume_hint,
  output logic        out_logout,
  output logic [1:0]  out_mode,
  output logic [3:0]  out_retry_count,
  output logic [3:0]  out_schedule_fail_count,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kas_pkg::kas_cfg_t    cfg;
  kas_pkg::kas_item_t   item_r;
  kas_pkg::kas_result_t res;
  kas_pkg::kas_result_t res_r;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic                 advance;
  logic                 fire;

  kas_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result stage can take a new result when empty or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.req_type    <= in_req_type;
      item_r.interval    <= in_interval;
      item_r.resp_code   <= in_resp_code;
      item_r.tid_matches <= in_tid_matches;
      item_r.send_failed <= in_send_failed;
    end
  end

  kas_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_send_request        = res_r.send_request;
  assign out_resume_hint         = res_r.resume_hint;
  assign out_logout              = res_r.logout;
  assign out_mode                = res_r.mode;
  assign out_retry_count         = res_r.retry_count;
  assign out_schedule_fail_count = res_r.schedule_fail_count;

endmodule

// ===== tb/sv/keepalive_supervisor_top_test.sv =====
// Self-checking testbench for the keep-alive supervisor top level.
`timescale 1ns / 100ps

module keepalive_supervisor_top_test;

  // Request types with no function in the block.
  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;

  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 155;
  localparam int PRINT_CAP = 100;

  typedef struct {
    kas_pkg::kas_item_t   item;
    bit                   typed;
    kas_pkg::kas_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = kas_pkg::REQ_STOP;
  logic [15:0] in_interval = '0;
  logic [9:0]  in_resp_code = '0;
  logic        in_tid_matches = 1'b0;
  logic        in_send_failed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_send_request;
  logic        out_resume_hint;
  logic        out_logout;
  logic [1:0]  out_mode;
  logic [3:0]  out_retry_count;
  logic [3:0]  out_schedule_fail_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keepalive_supervisor_top u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_req_type             (in_req_type),
    .in_interval             (in_interval),
    .in_resp_code            (in_resp_code),
    .in_tid_matches          (in_tid_matches),
    .in_send_failed          (in_send_failed),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_send_request        (out_send_request),
    .out_resume_hint         (out_resume_hint),
    .out_logout              (out_logout),
    .out_mode                (out_mode),
    .out_retry_count         (out_retry_count),
    .out_schedule_fail_count (out_schedule_fail_count),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always #6 clk = ~clk;

  // Session model state, kept in step with every accepted request.
  logic [1:0]  sess_mode = kas_pkg::MODE_IDLE;
  logic [15:0] reload_secs = '0;
  logic [15:0] countdown = '0;
  logic [15:0] timer_period = '0;
  bit          timer_on = 1'b0;
  logic [3:0]  retry_fails = '0;
  logic [3:0]  sched_fails = '0;
  bit          was_sched = 1'b0;
  bit          sent_from_active = 1'b0;
  logic [3:0]  lim_retries = kas_pkg::MAX_RETRIES_RST;
  logic [3:0]  lim_sched_errs = kas_pkg::MAX_SCHED_ERRS_RST;
  bit          o_send;
  bit          o_resume;
  bit          o_logout;

  kas_pkg::kas_result_t expected_results[$];
  int          mismatch_count = 0;
  int          result_index = 0;
  bit          jitter_on = 1'b1;
  int          stall_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at result %0d: %s got %0d expected %0d", result_index, what, got, want);
    mismatch_count++;
  endtask

  function automatic kas_pkg::kas_item_t item_of(input logic [2:0] req, input logic [15:0] ival,
                                                 input logic [9:0] code, input bit tid,
                                                 input bit failed);
    kas_pkg::kas_item_t it;
    it.req_type = req;
    it.interval = ival;
    it.resp_code = code;
    it.tid_matches = tid;
    it.send_failed = failed;
    return it;
  endfunction

  function automatic kas_pkg::kas_result_t result_of(input bit send, input bit resume,
                                                     input bit lout, input logic [1:0] mode,
                                                     input logic [3:0] retries,
                                                     input logic [3:0] scheds);
    kas_pkg::kas_result_t r;
    r.send_request = send;
    r.resume_hint = resume;
    r.logout = lout;
    r.mode = mode;
    r.retry_count = retries;
    r.schedule_fail_count = scheds;
    return r;
  endfunction

  // Counters hold at their top value; callers compare the unclipped sum.
  function automatic logic [3:0] clip4(input logic [4:0] n);
    return (n > 5'd15) ? kas_pkg::CNT_MAX : n[3:0];
  endfunction

  function automatic void load_timer(input logic [15:0] secs);
    if (secs != 16'd0) begin
      timer_period = secs;
      countdown = secs;
      timer_on = 1'b1;
    end
  endfunction

  function automatic void close_session();
    timer_on = 1'b0;
    countdown = '0;
    sess_mode = kas_pkg::MODE_IDLE;
    o_logout = 1'b1;
  endfunction

  function automatic void ask_keepalive(input bit sched);
    logic [4:0] n;
    if (sess_mode == kas_pkg::MODE_ACTIVE) begin
      sess_mode = kas_pkg::MODE_PENDING;
      was_sched = sched;
      sent_from_active = 1'b1;
      o_send = 1'b1;
    end else if (sess_mode == kas_pkg::MODE_PENDING) begin
      if (sched) begin
        n = {1'b0, sched_fails} + 5'd1;
        sched_fails = clip4(n);
        retry_fails = '0;
        if (n > {1'b0, lim_sched_errs}) begin
          close_session();
          return;
        end
      end
      sent_from_active = 1'b0;
      o_send = 1'b1;
    end
  endfunction

  // A failed send or matching transport error: retry now, or count a schedule failure.
  function automatic void handle_failure();
    logic [4:0] n;
    n = {1'b0, retry_fails} + 5'd1;
    retry_fails = clip4(n);
    if (n > {1'b0, lim_retries}) begin
      if (!was_sched) return;
      n = {1'b0, sched_fails} + 5'd1;
      sched_fails = clip4(n);
      retry_fails = '0;
      if (n > {1'b0, lim_sched_errs} && sess_mode != kas_pkg::MODE_IDLE) close_session();
    end else begin
      o_resume = 1'b1;
      if (sess_mode != kas_pkg::MODE_IDLE) ask_keepalive(was_sched);
    end
  endfunction

  function automatic kas_pkg::kas_result_t session_step(input kas_pkg::kas_item_t it);
    logic [15:0] half;
    o_send = 1'b0;
    o_resume = 1'b0;
    o_logout = 1'b0;
    half = {1'b0, it.interval[15:1]};
    case (it.req_type)
      kas_pkg::REQ_START: begin
        sess_mode = kas_pkg::MODE_ACTIVE;
        retry_fails = '0;
        sched_fails = '0;
        reload_secs = (half >= kas_pkg::RELOAD_LIMIT) ? half - kas_pkg::RELOAD_MARGIN : half;
        load_timer(reload_secs);
      end
      kas_pkg::REQ_STOP: begin
        timer_on = 1'b0;
        countdown = '0;
        sess_mode = kas_pkg::MODE_IDLE;
      end
      kas_pkg::REQ_RESP: begin
        if (sess_mode != kas_pkg::MODE_PENDING) begin
          load_timer(reload_secs);
        end else if (it.resp_code != kas_pkg::CODE_CLOSE_A &&
                     it.resp_code != kas_pkg::CODE_CLOSE_B &&
                     it.resp_code != kas_pkg::CODE_CLOSE_C) begin
          sess_mode = kas_pkg::MODE_ACTIVE;
          retry_fails = '0;
          sched_fails = '0;
        end else begin
          close_session();
        end
      end
      kas_pkg::REQ_ERROR: begin
        if (sess_mode == kas_pkg::MODE_PENDING && it.tid_matches) begin
          sess_mode = kas_pkg::MODE_ACTIVE;
          handle_failure();
        end
      end
      kas_pkg::REQ_TICK: begin
        if (timer_on) begin
          if (countdown <= 16'd1) begin
            countdown = timer_period;
            ask_keepalive(1'b1);
          end else begin
            countdown = countdown - 16'd1;
          end
        end
      end
      kas_pkg::REQ_SEND: begin
        if (sess_mode == kas_pkg::MODE_PENDING && it.send_failed) begin
          if (sent_from_active) sess_mode = kas_pkg::MODE_ACTIVE;
          handle_failure();
        end
      end
      default: ;
    endcase
    return result_of(o_send, o_resume, o_logout, sess_mode, retry_fails, sched_fails);
  endfunction

  // Random request, steered by the current session mode so sequences run deep.
  function automatic kas_pkg::kas_item_t random_item();
    int roll;
    int pick;
    logic [15:0] ival;
    logic [9:0] code;
    bit tid;
    bit fl;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    tid = 1'($urandom);
    fl = 1'($urandom);
    if (pick < 90) ival = 16'($urandom_range(0, 12));
    else if (pick < 95) ival = 16'($urandom_range(230, 250));
    else ival = 16'($urandom);
    code = 10'($urandom_range(0, 999));
    case (sess_mode)
      kas_pkg::MODE_IDLE: begin
        if (roll < 70) return item_of(kas_pkg::REQ_START, ival, code, tid, fl);
        if (roll < 80) return item_of(kas_pkg::REQ_TICK, ival, code, tid, fl);
        if (roll < 85) return item_of(kas_pkg::REQ_RESP, ival, code, tid, fl);
        if (roll < 90) return item_of(kas_pkg::REQ_ERROR, ival, code, tid, fl);
        if (roll < 95) return item_of(kas_pkg::REQ_SEND, ival, code, tid, fl);
      end
      kas_pkg::MODE_ACTIVE: begin
        if (roll < 8) return item_of(kas_pkg::REQ_START, ival, code, tid, fl);
        if (roll < 68) return item_of(kas_pkg::REQ_TICK, ival, code, tid, fl);
        if (roll < 78) return item_of(kas_pkg::REQ_RESP, ival, code, tid, fl);
        if (roll < 83) return item_of(kas_pkg::REQ_ERROR, ival, code, tid, fl);
        if (roll < 88) return item_of(kas_pkg::REQ_SEND, ival, code, tid, fl);
        if (roll < 95) return item_of(kas_pkg::REQ_STOP, ival, code, tid, fl);
      end
      default: begin
        if (roll < 35)
          return item_of(kas_pkg::REQ_SEND, ival, code, tid, $urandom_range(0, 4) != 0);
        if (roll < 55)
          return item_of(kas_pkg::REQ_ERROR, ival, code, $urandom_range(0, 4) != 0, fl);
        if (roll < 80) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) code = kas_pkg::CODE_CLOSE_A;
          else if (pick == 1) code = kas_pkg::CODE_CLOSE_B;
          else if (pick == 2) code = kas_pkg::CODE_CLOSE_C;
          return item_of(kas_pkg::REQ_RESP, ival, code, tid, fl);
        end
        if (roll < 90) return item_of(kas_pkg::REQ_TICK, ival, code, tid, fl);
        if (roll < 94) return item_of(kas_pkg::REQ_STOP, ival, code, tid, fl);
        if (roll < 97) return item_of(kas_pkg::REQ_START, ival, code, tid, fl);
      end
    endcase
    return item_of($urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B, 16'($urandom), code,
                   tid, fl);
  endfunction

  // Present one request and hold it until the transfer happens.
  task automatic drive_item(input kas_pkg::kas_item_t it,
                            output kas_pkg::kas_result_t predicted);
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_interval <= it.interval;
    in_resp_code <= it.resp_code;
    in_tid_matches <= it.tid_matches;
    in_send_failed <= it.send_failed;
    do @(posedge clk); while (in_stall);
    predicted = session_step(it);
  endtask

  // Occasional sender gap after a transfer.
  task automatic maybe_gap();
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // Write both limits, then read them back.
  task automatic set_limits(input logic [3:0] retries, input logic [3:0] scheds);
    logic [31:0] rd;
    apb_xfer(1'b1, {kas_pkg::REG_MAX_RETRIES, 2'b00}, {28'd0, retries}, rd);
    lim_retries = retries;
    apb_xfer(1'b1, {kas_pkg::REG_MAX_SCHED_ERRS, 2'b00}, {28'd0, scheds}, rd);
    lim_sched_errs = scheds;
    apb_xfer(1'b0, {kas_pkg::REG_MAX_RETRIES, 2'b00}, '0, rd);
    if (rd != {28'd0, retries})
      report_mismatch("max_retries readback", int'(rd), int'(retries));
    apb_xfer(1'b0, {kas_pkg::REG_MAX_SCHED_ERRS, 2'b00}, '0, rd);
    if (rd != {28'd0, scheds})
      report_mismatch("max_schedule_errors readback", int'(rd), int'(scheds));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    repeat (4) @(posedge clk);
  endtask

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (!jitter_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 7));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    kas_pkg::kas_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, mode", int'(out_mode), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_send_request != want.send_request)
          report_mismatch("send_request", int'(out_send_request), int'(want.send_request));
        if (out_resume_hint != want.resume_hint)
          report_mismatch("resume_hint", int'(out_resume_hint), int'(want.resume_hint));
        if (out_logout != want.logout)
          report_mismatch("logout", int'(out_logout), int'(want.logout));
        if (out_mode != want.mode)
          report_mismatch("mode", int'(out_mode), int'(want.mode));
        if (out_retry_count != want.retry_count)
          report_mismatch("retry_count", int'(out_retry_count), int'(want.retry_count));
        if (out_schedule_fail_count != want.schedule_fail_count)
          report_mismatch("schedule_fail_count", int'(out_schedule_fail_count),
                          int'(want.schedule_fail_count));
      end
      result_index++;
    end
  end

  // Stimulus: directed table, then random phases under different limits.
  initial begin
    dir_row_t             dir_table[$];
    kas_pkg::kas_result_t predicted;
    logic [3:0]           retry_set[PHASES];
    logic [3:0]           sched_set[PHASES];
    kas_pkg::kas_result_t idle0;
    kas_pkg::kas_result_t act0;

    idle0 = result_of(1'b0, 1'b0, 1'b0, kas_pkg::MODE_IDLE, 4'd0, 4'd0);
    act0 = result_of(1'b0, 1'b0, 1'b0, kas_pkg::MODE_ACTIVE, 4'd0, 4'd0);
    dir_table = '{
      // Idle block ignores everything except start.
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b1, idle0},
      '{item_of(REQ_RSVD_A, 16'd0, 10'd0, 1'b0, 1'b0), 1'b1, idle0},
      '{item_of(REQ_RSVD_B, 16'hFFFF, 10'd999, 1'b1, 1'b1), 1'b1, idle0},
      '{item_of(kas_pkg::REQ_ERROR, 16'd0, 10'd0, 1'b1, 1'b0), 1'b1, idle0},
      '{item_of(kas_pkg::REQ_SEND, 16'd0, 10'd0, 1'b0, 1'b1), 1'b1, idle0},
      '{item_of(kas_pkg::REQ_RESP, 16'd0, kas_pkg::CODE_CLOSE_A, 1'b0, 1'b0), 1'b1, idle0},
      // Zero period leaves the timer stopped.
      '{item_of(kas_pkg::REQ_START, 16'd0, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      // Period derivation around the margin boundary.
      '{item_of(kas_pkg::REQ_START, 16'hFFFF, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      '{item_of(kas_pkg::REQ_START, 16'd240, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      '{item_of(kas_pkg::REQ_START, 16'd239, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      '{item_of(kas_pkg::REQ_START, 16'd3, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      // Expiry, then failed sends: immediate retry, then a schedule failure.
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_SEND, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_SEND, 16'd0, 10'd0, 1'b0, 1'b1), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_SEND, 16'd0, 10'd0, 1'b0, 1'b1), 1'b0, idle0},
      // Response outside pending restarts the timer.
      '{item_of(kas_pkg::REQ_RESP, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      // Transport errors: a foreign transaction is ignored, a matching one retries.
      '{item_of(kas_pkg::REQ_ERROR, 16'd0, 10'd0, 1'b0, 1'b1), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_ERROR, 16'd0, 10'd0, 1'b1, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_RESP, 16'd0, 10'd998, 1'b0, 1'b0), 1'b0, idle0},
      // Closing response codes log the session out.
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_RESP, 16'd0, kas_pkg::CODE_CLOSE_C, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_START, 16'd2, 10'd0, 1'b0, 1'b0), 1'b1, act0},
      '{item_of(kas_pkg::REQ_TICK, 16'd0, 10'd0, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_RESP, 16'd0, kas_pkg::CODE_CLOSE_B, 1'b0, 1'b0), 1'b0, idle0},
      '{item_of(kas_pkg::REQ_STOP, 16'd0, 10'd0, 1'b0, 1'b0), 1'b1, idle0}
    };
    retry_set = '{kas_pkg::MAX_RETRIES_RST, 4'd0, 4'd15, 4'd15, 4'd0, 4'($urandom), 4'd2};
    sched_set = '{kas_pkg::MAX_SCHED_ERRS_RST, 4'd0, 4'd15, 4'd0, 4'd15, 4'($urandom), 4'd4};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      drive_item(dir_table[i].item, predicted);
      expected_results.push_back(dir_table[i].typed ? dir_table[i].want : predicted);
      maybe_gap();
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        in_valid <= 1'b0;
        drain_results();
        set_limits(retry_set[p], sched_set[p]);
        @(posedge clk);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Quiet stretches inside each phase; the last phase runs flat out.
        jitter_on = (p != PHASES - 1) && ((i % 60) < 40);
        drive_item(random_item(), predicted);
        expected_results.push_back(predicted);
        maybe_gap();
      end
    end

    in_valid <= 1'b0;
    drain_results();
    if (mismatch_count == 0) begin
      $display("[keepalive_supervisor_top] OK");
    end else begin
      $display("[keepalive_supervisor_top] ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #5_000_000;
    $display("[keepalive_supervisor_top] ERROR");
    $finish;
  end

endmodule
